### rtl/core/tksl_pkg.sv
// tksl_pkg: types and constants shared by the top-k score list block
// item, result and stored-entry structs, field widths, mode and status codes
// no dependencies
package tksl_pkg;

    localparam int CAPACITY       = 64;
    localparam int IDX_W          = $clog2(CAPACITY);
    localparam int CNT_W          = $clog2(CAPACITY + 2);
    localparam int SCORE_W        = 32;
    localparam int MASS_W         = 32;
    localparam int MASS_FRAC_BITS = 10;
    localparam int TAG_W          = 16;
    localparam int INDEX_W        = 6;
    localparam int POS_W          = 6;
    localparam int COUNT_W        = 7;
    localparam int BIN_W          = 19;
    localparam int KEEP_W         = 7;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MASS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    // register index, taken from paddr bit 2
    localparam logic REG_KEEP = 1'b0;
    localparam logic REG_MAX  = 1'b1;

    localparam logic [KEEP_W-1:0] KEEP_RESET     = 7'd10;
    localparam logic [MASS_W-1:0] MAX_MASS_RESET = 32'd10240000;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [SCORE_W-1:0] score;
        logic [MASS_W-1:0]         mass;
        logic [TAG_W-1:0]          tag;
        logic [INDEX_W-1:0]        index;
    } t_item;

    typedef struct packed {
        logic                      accepted;
        logic [POS_W-1:0]          position;
        logic [COUNT_W-1:0]        entry_count;
        logic [COUNT_W-1:0]        evicted;
        logic signed [SCORE_W-1:0] read_score;
        logic [MASS_W-1:0]         read_mass;
        logic [TAG_W-1:0]          read_tag;
        logic [BIN_W-1:0]          read_bin;
        logic [1:0]                status;
    } t_result;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [MASS_W-1:0]         mass;
        logic [TAG_W-1:0]          tag;
    } t_entry;

endpackage

### rtl/core/tksl_ram.sv
// tksl_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
module tksl_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tksl_bin_div.sv
// tksl_bin_div: mass bin by a fixed divisor, one reciprocal multiply, quotient ready the cycle after start
// used for the mass bin; no dependencies
module tksl_bin_div #(
    parameter int DIVISOR = 10,
    parameter int NUM_W   = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int SHIFT_W = $clog2(DIVISOR);
    localparam int K       = NUM_W + SHIFT_W;
    localparam int RECIP_W = NUM_W + 1;
    localparam int PROD_W  = K + NUM_W;
    localparam logic [63:0] ONE_K = 64'd1 << K;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((ONE_K + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic              r_done;
    logic [NUM_W-1:0]  r_quot;
    logic [PROD_W-1:0] w_prod;

    // rounded-up reciprocal, the bits above K give the exact quotient for NUM_W-bit inputs
    assign w_prod = PROD_W'(i_num) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= w_prod[K +: NUM_W];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/core/top_k_score_list_with_ties_unit.sv
// top_k_score_list_with_ties_unit: sorted top-k candidate store with ties kept at the cutoff
// depends on tksl_pkg, tksl_ram, tksl_bin_div
//
//  channel   signals                                   direction  handshake
//  command   start, busy, i_item                       in         start && !busy
//  result    o_done, o_result                          out        o_done, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     psel && penable && pwrite
//            prdata, pready
//
// insert walks the store through the one ram read port: find the rank, read the cutoff,
// scan the ties, then move entries down one a cycle
// read fetches the entry in S_RDATA, then S_DIV gives the mass bin by one reciprocal multiply
// clear and no-op give their result the cycle after the item
// reset empties the store at once (held count cleared), entries are not touched
// results are not held off: each o_done pulse is one item
module top_k_score_list_with_ties_unit #(
    parameter int BIN_WIDTH_DA = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tksl_pkg::PADDR_W-1:0]      paddr,
    input  logic [tksl_pkg::PDATA_W-1:0]      pwdata,
    output logic [tksl_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              start,
    input  tksl_pkg::t_item                   i_item,
    output logic                              busy,
    output logic                              o_done,
    output tksl_pkg::t_result                 o_result
);

    import tksl_pkg::*;

    localparam int ENTRY_W = $bits(t_entry);
    localparam int NUM_W   = MASS_W - MASS_FRAC_BITS;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_LAST   = 11'b000_0000_0010,
        S_FIND   = 11'b000_0000_0100,
        S_CUTSEL = 11'b000_0000_1000,
        S_CUTRD  = 11'b000_0001_0000,
        S_TIE    = 11'b000_0010_0000,
        S_COMMIT = 11'b000_0100_0000,
        S_SHIFT  = 11'b000_1000_0000,
        S_PUT    = 11'b001_0000_0000,
        S_RDATA  = 11'b010_0000_0000,
        S_DIV    = 11'b100_0000_0000
    } t_state;

    t_state                    r_state, n_state;
    t_item                     r_item;
    t_result                   r_res, n_res;
    logic                      r_done, n_done;
    logic [CNT_W-1:0]          r_held, n_held;
    logic [CNT_W-1:0]          r_pos, n_pos;
    logic [CNT_W-1:0]          r_kept, n_kept;
    logic [CNT_W-1:0]          r_j, n_j;
    logic signed [SCORE_W-1:0] r_cut, n_cut;
    logic [IDX_W-1:0]          r_ra, n_ra;
    logic [KEEP_W-1:0]         r_keep;
    logic [MASS_W-1:0]         r_max;

    logic [ENTRY_W-1:0]        w_rdata;
    t_entry                    w_rd;
    t_entry                    w_wdata;
    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [NUM_W-1:0]          w_quot;
    logic [CNT_W-1:0]          w_keep;
    logic [CNT_W-1:0]          w_total;
    logic [CNT_W-1:0]          w_cidx;
    logic [CNT_W-1:0]          w_j_inc;
    logic [IDX_W-1:0]          w_tie_addr;
    logic signed [SCORE_W-1:0] w_tie_val;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_RESET;
            r_max  <= MAX_MASS_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_KEEP: r_keep <= pwdata[KEEP_W-1:0];
                REG_MAX:  r_max  <= pwdata[MASS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_KEEP: prdata = PDATA_W'(r_keep);
            REG_MAX:  prdata = PDATA_W'(r_max);
        endcase
    end

    // entry store, read data always shows the entry at r_ra
    tksl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_ra),
        .o_rdata (w_rdata)
    );

    tksl_bin_div #(
        .DIVISOR (BIN_WIDTH_DA),
        .NUM_W   (NUM_W)
    ) u_bin_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_rd.mass[MASS_W-1:MASS_FRAC_BITS]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_rd = t_entry'(w_rdata);

    // keep count of zero acts as one, above capacity as capacity
    always_comb begin
        if (r_keep == '0) begin
            w_keep = CNT_W'(1);
        end else if (r_keep > KEEP_W'(CAPACITY)) begin
            w_keep = CNT_W'(CAPACITY);
        end else begin
            w_keep = CNT_W'(r_keep);
        end
    end

    assign w_total    = r_held + CNT_W'(1);
    assign w_cidx     = w_keep - CNT_W'(1);
    assign w_j_inc    = r_j + CNT_W'(1);
    // rank j of the merged list sits at j below the new entry, at j-1 after it
    assign w_tie_addr = (w_keep < r_pos) ? IDX_W'(w_keep) : IDX_W'(w_cidx);
    assign w_tie_val  = (r_j == r_pos) ? r_item.score : w_rd.score;

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_done      = 1'b0;
        n_held      = r_held;
        n_pos       = r_pos;
        n_kept      = r_kept;
        n_j         = r_j;
        n_cut       = r_cut;
        n_ra        = r_ra;
        w_we        = 1'b0;
        w_waddr     = r_ra;
        w_wdata     = w_rd;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res             = '0;
                    n_res.entry_count = COUNT_W'(r_held);
                    unique case (i_item.mode)
                        MODE_INSERT: begin
                            if (i_item.mass > r_max) begin
                                n_res.status = ST_MASS;
                                n_done       = 1'b1;
                            end else if (r_held == '0) begin
                                n_pos   = '0;
                                n_state = S_CUTSEL;
                            end else begin
                                n_ra    = IDX_W'(r_held - CNT_W'(1));
                                n_state = S_LAST;
                            end
                        end
                        MODE_READ: begin
                            if (CNT_W'(i_item.index) >= r_held) begin
                                n_res.status = ST_INDEX;
                                n_done       = 1'b1;
                            end else begin
                                n_ra    = IDX_W'(i_item.index);
                                n_state = S_RDATA;
                            end
                        end
                        MODE_CLEAR: begin
                            n_held            = '0;
                            n_res.entry_count = '0;
                            n_done            = 1'b1;
                        end
                        MODE_NOP: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_LAST: begin
                // not above the last entry: goes to the end
                if ($signed(r_item.score) <= $signed(w_rd.score)) begin
                    n_pos   = r_held;
                    n_state = S_CUTSEL;
                end else begin
                    n_ra    = '0;
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if ($signed(r_item.score) >= $signed(w_rd.score)) begin
                    n_pos   = CNT_W'(r_ra);
                    n_state = S_CUTSEL;
                end else begin
                    n_ra = r_ra + IDX_W'(1);
                end
            end
            S_CUTSEL: begin
                if (w_total <= w_keep) begin
                    n_kept  = w_total;
                    n_state = S_COMMIT;
                end else begin
                    n_j = w_keep;
                    if (w_cidx == r_pos) begin
                        n_cut   = r_item.score;
                        n_ra    = w_tie_addr;
                        n_state = S_TIE;
                    end else begin
                        n_ra    = (w_cidx < r_pos) ? IDX_W'(w_cidx)
                                                   : IDX_W'(w_cidx - CNT_W'(1));
                        n_state = S_CUTRD;
                    end
                end
            end
            S_CUTRD: begin
                n_cut   = w_rd.score;
                n_ra    = w_tie_addr;
                n_state = S_TIE;
            end
            S_TIE: begin
                if (w_tie_val == r_cut) begin
                    if (w_j_inc == w_total) begin
                        n_kept  = w_total;
                        n_state = S_COMMIT;
                    end else begin
                        n_j  = w_j_inc;
                        n_ra = (w_j_inc < r_pos) ? IDX_W'(w_j_inc) : IDX_W'(r_j);
                    end
                end else begin
                    n_kept  = r_j;
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (r_kept > CNT_W'(CAPACITY)) begin
                    // ties overflow the store: drop the item
                    n_res.status = ST_FULL;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_held            = r_kept;
                    n_res.entry_count = COUNT_W'(r_kept);
                    n_res.evicted     = COUNT_W'(w_total - r_kept);
                    n_res.position    = POS_W'(r_pos);
                    if (r_pos < r_kept) begin
                        n_res.accepted = 1'b1;
                        if ((r_pos + CNT_W'(1)) < r_kept) begin
                            n_ra    = IDX_W'(r_kept - CNT_W'(2));
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_PUT;
                        end
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                // move entries down from the bottom up to the insert rank
                w_we    = 1'b1;
                w_waddr = r_ra + IDX_W'(1);
                w_wdata = w_rd;
                if (CNT_W'(r_ra) == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_ra = r_ra - IDX_W'(1);
                end
            end
            S_PUT: begin
                w_we          = 1'b1;
                w_waddr       = IDX_W'(r_pos);
                w_wdata.score = r_item.score;
                w_wdata.mass  = r_item.mass;
                w_wdata.tag   = r_item.tag;
                n_done        = 1'b1;
                n_state       = S_IDLE;
            end
            S_RDATA: begin
                n_res.read_score = w_rd.score;
                n_res.read_mass  = w_rd.mass;
                n_res.read_tag   = w_rd.tag;
                n_res.status     = (w_rd.mass > r_max) ? ST_MASS : ST_OK;
                w_div_start      = 1'b1;
                n_state          = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res.read_bin = BIN_W'(w_quot);
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_held  <= '0;
            r_ra    <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_held  <= n_held;
            r_ra    <= n_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_item <= i_item;
        end
        r_res  <= n_res;
        r_pos  <= n_pos;
        r_kept <= n_kept;
        r_j    <= n_j;
        r_cut  <= n_cut;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
